// ===== src/vlrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Record stack package
// Shared sizes, field codes and beat structures of the record stack.
// ----------------------------------------------------------------------------
package vlrs_pkg;

  localparam int DEPTH     = 1024;
  localparam int AW        = $clog2(DEPTH);
  localparam int TW        = AW + 1;
  localparam int MAX_READ  = 64;
  localparam int RLW       = 10;
  localparam int CAPW      = 7;
  localparam int HDR_BYTES = 4;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_PEEK  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;
  localparam logic [1:0] ST_ACCEPTED = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      data_byte;
    logic [RLW-1:0]  record_length;
    logic            byte_last;
    logic [CAPW-1:0] read_capacity;
  } item_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [7:0]     out_byte;
    logic           out_valid;
    logic [RLW-1:0] stored_length;
    logic           result_last;
  } result_t;

endpackage

// ===== src/vlrs_if.sv =====
// ----------------------------------------------------------------------------
// Record stack channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface vlrs_req_if;
  logic            valid;
  logic            ready;
  vlrs_pkg::item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
  modport mon(input valid, input ready, input payload);
endinterface

interface vlrs_rsp_if;
  logic              valid;
  logic              ready;
  vlrs_pkg::result_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
  modport mon(input valid, input ready, input payload);
endinterface

// ===== src/vlrs_engine.sv =====
// ----------------------------------------------------------------------------
// Record stack engine
// Byte store and sequencer that pushes, fills, reads and frees records.
// ----------------------------------------------------------------------------
module vlrs_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vlrs_pkg::item_t   item,
  output logic              idle,
  output logic              emit,
  output vlrs_pkg::result_t emit_data,
  input  logic              emit_ok
);
  import vlrs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_HDR0  = 4'd2;
  localparam logic [3:0] S_HDR1  = 4'd3;
  localparam logic [3:0] S_STORE = 4'd4;
  localparam logic [3:0] S_FILL  = 4'd5;
  localparam logic [3:0] S_RDH0  = 4'd6;
  localparam logic [3:0] S_RDH1  = 4'd7;
  localparam logic [3:0] S_RDH2  = 4'd8;
  localparam logic [3:0] S_RDB   = 4'd9;
  localparam logic [3:0] S_BYTE  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]      state;
  item_t           cur;
  result_t         res;
  logic [TW-1:0]   top_index;
  logic            push_active;
  logic            push_refused;
  logic [AW-1:0]   push_base;
  logic [RLW:0]    push_count;
  logic [RLW-1:0]  push_len;
  logic [RLW-1:0]  hdr;
  logic [CAPW-1:0] rd_num;
  logic [CAPW-1:0] rd_idx;
  logic [7:0]      rd_data;
  logic [7:0]      mem [DEPTH];

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_wdata;

  logic [RLW:0]    cnt_inc;
  logic            refuse_end;
  logic            no_room;
  logic [TW-1:0]   base_calc;
  logic [RLW:0]    len_ext;
  logic            has_byte;
  logic [RLW:0]    cnt_store;
  logic            store_done;
  logic [AW-1:0]   data_ptr;
  logic [CAPW-1:0] cap_c;
  logic [RLW-1:0]  h_new;
  logic [CAPW-1:0] n_new;
  logic [RLW-1:0]  hdr_cur;
  logic [TW:0]     pop_sum;
  logic [TW-1:0]   pop_top;
  logic            byte_final;
  logic [1:0]      exec_st;

  always_comb begin
    cnt_inc    = push_count + (RLW+1)'(1);
    refuse_end = cur.byte_last || (cnt_inc >= {1'b0, cur.record_length});
    no_room    = top_index < (TW'(cur.record_length) + TW'(HDR_BYTES));
    base_calc  = top_index - TW'(cur.record_length) - TW'(HDR_BYTES);
    len_ext    = {1'b0, push_len};
    has_byte   = push_count < len_ext;
    cnt_store  = has_byte ? cnt_inc : push_count;
    store_done = (cnt_store >= len_ext) || cur.byte_last;
    data_ptr   = push_base + AW'(HDR_BYTES) + push_count[AW-1:0];
    cap_c      = (cur.read_capacity > CAPW'(MAX_READ)) ? CAPW'(MAX_READ) : cur.read_capacity;
    h_new      = {rd_data[1:0], hdr[7:0]};
    n_new      = (RLW'(cap_c) > h_new) ? h_new[CAPW-1:0] : cap_c;
    hdr_cur    = (state == S_RDH2) ? h_new : hdr;
    pop_sum    = {1'b0, top_index} + (TW+1)'(hdr_cur) + (TW+1)'(HDR_BYTES);
    pop_top    = (pop_sum > (TW+1)'(DEPTH)) ? TW'(DEPTH) : pop_sum[TW-1:0];
    byte_final = (rd_idx + CAPW'(1)) == rd_num;
    exec_st    = (cur.kind == KIND_PUSH) ? ST_REFUSED :
                 ((cur.kind == KIND_CLEAR) ? ST_DONE : ST_EMPTY);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = push_base;
    mem_wdata = 8'd0;
    mem_raddr = top_index[AW-1:0];
    case (state)
      S_HDR0: begin
        mem_we    = 1'b1;
        mem_wdata = push_len[7:0];
      end
      S_HDR1: begin
        mem_we    = 1'b1;
        mem_waddr = push_base + AW'(1);
        mem_wdata = {6'd0, push_len[9:8]};
      end
      S_STORE: begin
        mem_we    = has_byte;
        mem_waddr = data_ptr;
        mem_wdata = cur.data_byte;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = data_ptr;
      end
      S_RDH0: begin
        mem_re = 1'b1;
      end
      S_RDH1: begin
        mem_re    = 1'b1;
        mem_raddr = top_index[AW-1:0] + AW'(1);
      end
      S_RDB: begin
        mem_re    = 1'b1;
        mem_raddr = top_index[AW-1:0] + AW'(HDR_BYTES) + AW'(rd_idx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    idle      = (state == S_IDLE);
    emit      = (state == S_EMIT) || (state == S_BYTE);
    emit_data = res;
    if (state == S_BYTE) begin
      emit_data.status        = ST_DONE;
      emit_data.out_byte      = rd_data;
      emit_data.out_valid     = 1'b1;
      emit_data.stored_length = hdr;
      emit_data.result_last   = byte_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      top_index    <= TW'(DEPTH);
      push_active  <= 1'b0;
      push_refused <= 1'b0;
      push_count   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res <= '{status: exec_st, out_byte: 8'd0, out_valid: 1'b0,
                   stored_length: '0, result_last: 1'b1};
          if (cur.kind == KIND_PUSH) begin
            if (push_refused) begin
              push_count <= refuse_end ? '0 : cnt_inc;
              if (refuse_end) begin
                push_refused <= 1'b0;
              end
              state <= S_EMIT;
            end else if (push_active) begin
              state <= S_STORE;
            end else if (no_room) begin
              if (cur.byte_last || (cur.record_length <= RLW'(1))) begin
                push_count <= '0;
              end else begin
                push_count   <= (RLW+1)'(1);
                push_refused <= 1'b1;
              end
              state <= S_EMIT;
            end else begin
              push_base   <= base_calc[AW-1:0];
              push_len    <= cur.record_length;
              push_count  <= '0;
              push_active <= 1'b1;
              state       <= S_HDR0;
            end
          end else begin
            push_active  <= 1'b0;
            push_refused <= 1'b0;
            push_count   <= '0;
            if (cur.kind == KIND_CLEAR) begin
              top_index <= TW'(DEPTH);
              state     <= S_EMIT;
            end else if (top_index >= TW'(DEPTH)) begin
              state <= S_EMIT;
            end else begin
              state <= S_RDH0;
            end
          end
        end
        S_HDR0: begin
          state <= S_HDR1;
        end
        S_HDR1: begin
          state <= S_STORE;
        end
        S_STORE: begin
          res <= '{status: store_done ? ST_DONE : ST_ACCEPTED, out_byte: 8'd0,
                   out_valid: 1'b0, stored_length: '0, result_last: 1'b1};
          if (store_done) begin
            if (cnt_store < len_ext) begin
              push_count <= cnt_store;
              state      <= S_FILL;
            end else begin
              top_index   <= TW'(push_base);
              push_active <= 1'b0;
              push_count  <= '0;
              state       <= S_EMIT;
            end
          end else begin
            push_count <= cnt_store;
            state      <= S_EMIT;
          end
        end
        S_FILL: begin
          if (cnt_inc >= len_ext) begin
            top_index   <= TW'(push_base);
            push_active <= 1'b0;
            push_count  <= '0;
            state       <= S_EMIT;
          end else begin
            push_count <= cnt_inc;
          end
        end
        S_RDH0: begin
          state <= S_RDH1;
        end
        S_RDH1: begin
          hdr[7:0] <= rd_data;
          state    <= S_RDH2;
        end
        S_RDH2: begin
          hdr    <= h_new;
          rd_num <= n_new;
          rd_idx <= '0;
          if (n_new == '0) begin
            res <= '{status: ST_DONE, out_byte: 8'd0, out_valid: 1'b0,
                     stored_length: h_new, result_last: 1'b1};
            if (cur.kind == KIND_POP) begin
              top_index <= pop_top;
            end
            state <= S_EMIT;
          end else begin
            state <= S_RDB;
          end
        end
        S_RDB: begin
          state <= S_BYTE;
        end
        S_BYTE: begin
          if (emit_ok) begin
            if (byte_final) begin
              if (cur.kind == KIND_POP) begin
                top_index <= pop_top;
              end
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + CAPW'(1);
              state  <= S_RDB;
            end
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/variable_length_record_stack_top.sv =====
// ----------------------------------------------------------------------------
// Variable-length record stack
// A byte store holding a downward-growing stack of length-prefixed records.
// ----------------------------------------------------------------------------
// Requests arrive on req, one beat per push byte, pop, peek or clear. Each
// request gives one or more beats on rsp, the final one marked by
// result_last. A push byte or clear gives one beat; a pop or peek gives one
// beat per returned record byte, or one beat when the stack is empty or no
// byte is returned.
// Timing: req.ready is high only while the sequencer is idle, and all work
// goes through the single-port byte store, one access per cycle. The first
// byte of a record also writes two header bytes, and a record closed early
// zero-fills each remaining byte before it answers. A pop or peek reads the
// two header bytes and then each returned byte in turn; empty, refused and
// clear answers need no store access.
// Reset empties the stack and drops any partial push; the store contents
// are not cleared. Results pass through an output register, so a new
// request can be taken while the last beat waits; when rsp stalls, the
// sequencer holds at its next beat until the register frees.
module variable_length_record_stack_top (
  input logic        clk,
  input logic        rst,
  vlrs_req_if.sink   req,
  vlrs_rsp_if.source rsp
);
  import vlrs_pkg::*;

  logic    idle;
  logic    emit;
  logic    emit_ok;
  logic    load;
  result_t emit_data;

  assign req.ready = idle;
  assign emit_ok   = !rsp.valid || rsp.ready;
  assign load      = emit && emit_ok;

  vlrs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && idle),
    .item      (req.payload),
    .idle      (idle),
    .emit      (emit),
    .emit_data (emit_data),
    .emit_ok   (emit_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.payload <= emit_data;
    end
  end

endmodule

// ===== src/vlrs_checker.sv =====
// ----------------------------------------------------------------------------
// Record stack checker
// Port-level properties of the record stack, bound to its top level.
// ----------------------------------------------------------------------------
module vlrs_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input vlrs_pkg::result_t rsp_payload
);
  import vlrs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("Stalled result beat changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request taken while the previous one was still at work.");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_ready)
    else $error("Block not idle after reset.");

  a_single_answer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_payload.status != ST_DONE) |->
      rsp_payload.result_last && !rsp_payload.out_valid &&
      (rsp_payload.stored_length == '0))
    else $error("Status beat is not a lone final beat without data.");

endmodule

bind variable_length_record_stack_top vlrs_checker u_vlrs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ===== tb/variable_length_record_stack_top_tb.sv =====
// ----------------------------------------------------------------------------
// Record stack testbench
// Drives push, pop, peek and clear beats into the record stack under random
// backpressure and idle gaps. A cycle-free shadow of the stack works out the
// answer beats of each accepted request, and every answer beat is checked
// against them in order.
// ----------------------------------------------------------------------------
module variable_length_record_stack_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vlrs_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  vlrs_req_if req_ch();
  vlrs_rsp_if rsp_ch();

  variable_length_record_stack_top DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  item_t   request_queue[$];
  result_t awaited[$];
  int      items_queued;
  int      fail_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      hold_req;
  bit      hold_ack;
  int      hold_left;
  result_t want_beat;
  result_t got_beat;

  bit [7:0]    shadow_mem[DEPTH];
  int unsigned shadow_top;
  bit          pushing;
  bit          refusing;
  int unsigned rec_base;
  int unsigned rec_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("variable_length_record_stack_top_tb failed");
    $finish;
  end

  function automatic int unsigned header_at(int unsigned a);
    return {shadow_mem[a + 3], shadow_mem[a + 2], shadow_mem[a + 1], shadow_mem[a]};
  endfunction

  function automatic logic [1:0] store_record_byte(logic [7:0] b, logic last_flag);
    int unsigned len;
    int unsigned i;
    len = header_at(rec_base);
    if (rec_count < len) begin
      shadow_mem[rec_base + 4 + rec_count] = b;
      rec_count++;
    end
    if (rec_count >= len || last_flag) begin
      for (i = rec_count; i < len; i++) shadow_mem[rec_base + 4 + i] = 8'h00;
      shadow_top = rec_base;
      pushing = 1'b0;
      rec_count = 0;
      return ST_DONE;
    end
    return ST_ACCEPTED;
  endfunction

  function automatic void predict_answers(item_t it);
    int unsigned rl;
    int unsigned cap;
    int unsigned h;
    int unsigned n;
    int unsigned i;
    result_t r;
    rl = 32'(it.record_length);
    cap = 32'(it.read_capacity);
    r = '0;
    r.result_last = 1'b1;
    if (it.kind == KIND_PUSH) begin
      if (refusing) begin
        rec_count++;
        if (it.byte_last || rec_count >= rl) begin
          refusing = 1'b0;
          rec_count = 0;
        end
        r.status = ST_REFUSED;
      end else if (pushing) begin
        r.status = store_record_byte(it.data_byte, it.byte_last);
      end else if (shadow_top < rl + 4) begin
        refusing = !(it.byte_last || rl <= 1);
        rec_count = refusing ? 1 : 0;
        r.status = ST_REFUSED;
      end else begin
        rec_base = shadow_top - rl - 4;
        shadow_mem[rec_base] = 8'(rl);
        shadow_mem[rec_base + 1] = 8'(rl >> 8);
        shadow_mem[rec_base + 2] = 8'h00;
        shadow_mem[rec_base + 3] = 8'h00;
        rec_count = 0;
        pushing = 1'b1;
        r.status = store_record_byte(it.data_byte, it.byte_last);
      end
      awaited.push_back(r);
    end else begin
      pushing = 1'b0;
      refusing = 1'b0;
      rec_count = 0;
      if (it.kind == KIND_CLEAR) begin
        shadow_top = DEPTH;
        r.status = ST_DONE;
        awaited.push_back(r);
      end else if (shadow_top >= DEPTH) begin
        r.status = ST_EMPTY;
        awaited.push_back(r);
      end else begin
        h = header_at(shadow_top);
        if (h > DEPTH) h = DEPTH;
        n = (cap < MAX_READ) ? cap : MAX_READ;
        if (h < n) n = h;
        r.status = ST_DONE;
        r.stored_length = RLW'(h);
        if (n == 0) begin
          awaited.push_back(r);
        end else begin
          for (i = 0; i < n; i++) begin
            r.out_byte = shadow_mem[shadow_top + 4 + i];
            r.out_valid = 1'b1;
            r.result_last = (i + 1 == n);
            awaited.push_back(r);
          end
        end
        if (it.kind == KIND_POP) begin
          shadow_top = (shadow_top + 4 + h > DEPTH) ? DEPTH : shadow_top + 4 + h;
        end
      end
    end
  endfunction

  function automatic string beat_text(result_t r);
    return $sformatf("status=%0d byte=%02h valid=%0b length=%0d last=%0b",
                     r.status, r.out_byte, r.out_valid, r.stored_length, r.result_last);
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.payload <= request_queue.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_ack <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      shadow_top = DEPTH;
      pushing = 1'b0;
      refusing = 1'b0;
      rec_base = 0;
      rec_count = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_answers(req_ch.payload);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_beat = rsp_ch.payload;
        if (awaited.size() == 0) begin
          report_failure($sformatf("unexpected beat: %s", beat_text(got_beat)));
        end else begin
          want_beat = awaited.pop_front();
          if (got_beat.status !== want_beat.status ||
              got_beat.out_byte !== want_beat.out_byte ||
              got_beat.out_valid !== want_beat.out_valid ||
              got_beat.stored_length !== want_beat.stored_length ||
              got_beat.result_last !== want_beat.result_last) begin
            report_failure($sformatf("mismatch: expected %s, got %s",
                                     beat_text(want_beat), beat_text(got_beat)));
          end
        end
      end
    end
  end

  task automatic add_item(logic [1:0] kind, logic [7:0] db, int rl, bit last_flag, int cap);
    item_t it;
    it.kind = kind;
    it.data_byte = db;
    it.record_length = RLW'(rl);
    it.byte_last = last_flag;
    it.read_capacity = CAPW'(cap);
    request_queue.push_back(it);
    items_queued++;
  endtask

  task automatic add_record(int rl, int sent, bit mark_last, bit vary_len);
    int i;
    for (i = 0; i < sent; i++) begin
      add_item(KIND_PUSH, 8'($urandom_range(255)),
               (vary_len && i > 0) ? $urandom_range(1020) : rl,
               mark_last && (i == sent - 1), $urandom_range(64));
    end
  endtask

  function automatic int pick_capacity();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 0;
    if (sel < 3) return MAX_READ;
    return $urandom_range(1, MAX_READ);
  endfunction

  task automatic add_random(int count);
    int stop_at;
    int pick;
    int rl;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        rl = ($urandom_range(7) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 8);
        add_record(rl, (rl == 0) ? 1 : rl, 1'b1, 1'b0);
      end else if (pick < 47) begin
        add_record($urandom_range(200, 1020), $urandom_range(1, 3), 1'b1, 1'b0);
      end else if (pick < 52) begin
        rl = $urandom_range(1, 8);
        add_record(rl, rl, 1'b0, 1'b0);
      end else if (pick < 56) begin
        rl = $urandom_range(2, 10);
        add_record(rl, rl, 1'b1, 1'b1);
      end else if (pick < 60) begin
        rl = $urandom_range(2, 20);
        add_record(rl, $urandom_range(1, rl - 1), 1'b0, 1'b0);
        add_item($urandom_range(1) ? KIND_POP : KIND_PEEK, 8'($urandom_range(255)),
                 $urandom_range(1020), 1'($urandom_range(1)), pick_capacity());
      end else if (pick < 78) begin
        add_item(KIND_POP, 8'($urandom_range(255)), $urandom_range(1020),
                 1'($urandom_range(1)), pick_capacity());
      end else if (pick < 93) begin
        add_item(KIND_PEEK, 8'($urandom_range(255)), $urandom_range(1020),
                 1'($urandom_range(1)), pick_capacity());
      end else if (pick < 95) begin
        add_item(KIND_CLEAR, 8'($urandom_range(255)), $urandom_range(1020),
                 1'($urandom_range(1)), $urandom_range(64));
      end else begin
        add_item(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(1020),
                 1'($urandom_range(1)), $urandom_range(64));
      end
    end
  endtask

  task automatic wait_all_answered();
    while (request_queue.size() != 0 || req_ch.valid || awaited.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 61;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_item(KIND_POP, 8'h00, 0, 1'b0, MAX_READ);
    add_item(KIND_PEEK, 8'hFF, 1020, 1'b1, 0);
    add_item(KIND_PUSH, 8'h00, 3, 1'b0, 0);
    add_item(KIND_PUSH, 8'hFF, 3, 1'b0, 0);
    add_item(KIND_PUSH, 8'h5A, 3, 1'b1, 0);
    add_item(KIND_PEEK, 8'h00, 0, 1'b0, MAX_READ);
    add_item(KIND_PEEK, 8'h00, 0, 1'b0, 0);
    add_item(KIND_PUSH, 8'hA5, 2, 1'b0, 0);
    add_item(KIND_PUSH, 8'h3C, 9, 1'b0, 0);
    add_item(KIND_PUSH, 8'hFF, 0, 1'b0, 0);
    add_item(KIND_POP, 8'h00, 0, 1'b0, 5);
    add_item(KIND_POP, 8'h00, 0, 1'b0, 1);
    add_item(KIND_PUSH, 8'h77, 5, 1'b1, 0);
    add_item(KIND_PEEK, 8'h00, 0, 1'b0, 63);
    add_item(KIND_PUSH, 8'h11, 4, 1'b0, 0);
    add_item(KIND_PEEK, 8'h00, 0, 1'b0, 2);
    add_item(KIND_CLEAR, 8'h00, 0, 1'b0, 0);
    add_item(KIND_PUSH, 8'h80, 1020, 1'b1, 0);
    add_item(KIND_PUSH, 8'h01, 0, 1'b0, 0);
    add_item(KIND_PUSH, 8'h02, 2, 1'b0, 0);
    add_item(KIND_PUSH, 8'h03, 2, 1'b0, 0);
    add_item(KIND_PUSH, 8'h01, 7, 1'b0, 0);
    add_item(KIND_POP, 8'h00, 0, 1'b0, MAX_READ);
    add_item(KIND_POP, 8'h00, 0, 1'b0, MAX_READ);
    add_item(KIND_CLEAR, 8'hFF, 1020, 1'b1, 127);

    add_random(110);
    wait_all_answered();

    send_idle_pct = 0;
    hold_req = ~hold_req;
    add_record(40, 40, 1'b1, 1'b0);
    add_item(KIND_PEEK, 8'h00, 0, 1'b0, MAX_READ);
    add_item(KIND_POP, 8'h00, 0, 1'b0, MAX_READ);
    wait_all_answered();

    send_idle_pct = 61;
    recv_idle_pct = 17;
    add_random(110);
    wait_all_answered();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(120);
    wait_all_answered();

    repeat (50) @(posedge clk);
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("variable_length_record_stack_top_tb passed");
    end else begin
      $display("variable_length_record_stack_top_tb failed");
    end
    $finish;
  end

endmodule
